// ===== rtl/core/sidc_pkg.sv =====
// shared types and constants for the signed integer to decimal character block
package sidc_pkg;

   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 8;
   localparam int COUNT_W = 4;
   localparam int DIGIT_W = 4;

   // at most ten decimal digits in an unsigned 32-bit magnitude
   localparam int MAX_DIGITS = 10;
   localparam int DIDX_W     = $clog2(MAX_DIGITS);

   typedef logic [VALUE_W-1:0]   value_type;
   typedef logic [CHAR_W-1:0]    char_type;
   typedef logic [COUNT_W-1:0]   count_type;
   typedef logic [DIGIT_W-1:0]   digit_type;
   typedef logic [DIDX_W-1:0]    didx_type;
   typedef logic [2*VALUE_W-1:0] prod_type;

   localparam char_type CHAR_ZERO  = 8'd48;
   localparam char_type CHAR_MINUS = 8'd45;

   // reciprocal of ten: q = (x * 0xCCCCCCCD) >> 35, exact for all 32-bit x
   localparam value_type RECIP_TEN = 32'hCCCC_CCCD;
   localparam int        RECIP_SHIFT = 35;
   localparam didx_type  LAST_DIGIT_IDX = didx_type'(0);

endpackage

// ===== rtl/core/sidc_if.sv =====
// request and response channel interfaces
interface sidc_req_if;
   import sidc_pkg::*;

   logic              valid;
   logic              ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface sidc_rsp_if;
   import sidc_pkg::*;

   logic      valid;
   logic      ready;
   char_type  character;
   count_type chars_so_far;
   logic      last;

   modport source (output valid, output character, output chars_so_far, output last,
                   input ready);
   modport sink   (input valid, input character, input chars_so_far, input last,
                   output ready);
endinterface

// ===== rtl/core/sidc_div10.sv =====
// divide-by-ten unit: registered reciprocal product, quotient and remainder out
module sidc_div10 (
   input  logic                clock,
   input  logic                start,
   input  sidc_pkg::value_type dividend,
   output sidc_pkg::value_type quotient,
   output sidc_pkg::digit_type remainder
);
   import sidc_pkg::*;

   value_type dividend_ff;
   prod_type  prod_ff;
   value_type q10;

   always_ff @(posedge clock) begin
      if (start) begin
         dividend_ff <= dividend;
         prod_ff     <= prod_type'(dividend) * prod_type'(RECIP_TEN);
      end
   end

   assign quotient  = value_type'(prod_ff >> RECIP_SHIFT);
   // q*10 as two shifted copies
   assign q10       = (quotient << 3) + (quotient << 1);
   assign remainder = digit_type'(dividend_ff - q10);

endmodule

// ===== rtl/core/signed_int_to_decimal_chars.sv =====
// top level: prints a signed 32-bit integer as decimal ascii, one character per response
//
// Usage
//   req_bus : one signed 32-bit value per request, taken when valid and ready are high.
//             ready is high only while the block is idle; one value is in work at a time.
//   rsp_bus : one ascii character per response, most significant digit first, preceded
//             by '-' for a negative value. chars_so_far counts characters of this value
//             including the current one; last marks the final character.
// Timing
//   After a request is taken, one divide-by-ten step runs per cycle through a shared
//   reciprocal multiplier that splits the value into its decimal digits.
//   The characters then leave from an output register at one per cycle while the
//   receiver is ready. A value has n characters (1..11); ready returns the cycle after
//   the last character is taken.
// Reset
//   Synchronous active-high reset returns the sequencer to idle and drops rsp valid.
// Stalls
//   While rsp ready is low the current character is held and no new one is loaded;
//   the block stays busy until every character of the value has been taken.
module signed_int_to_decimal_chars (
   input  logic            clock,
   input  logic            reset,
   sidc_req_if.sink        req_bus,
   sidc_rsp_if.source      rsp_bus
);
   import sidc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       neg_ff, neg_in;
   didx_type   ndig_ff, ndig_in;
   didx_type   idx_ff, idx_in;
   logic       sign_pend_ff, sign_pend_in;
   logic       done_ff, done_in;
   count_type  count_ff, count_in;

   digit_type  digits_ff [MAX_DIGITS];

   logic       rsp_valid_ff, rsp_valid_in;
   char_type   rsp_char_ff, rsp_char_in;
   count_type  rsp_count_ff, rsp_count_in;
   logic       rsp_last_ff, rsp_last_in;

   logic       accept;
   logic       load_ok;
   logic       div_start;
   value_type  div_dividend;
   value_type  quotient;
   digit_type  remainder;
   value_type  raw;
   logic       raw_neg;
   value_type  raw_mag;

   assign raw     = value_type'(req_bus.value);
   assign raw_neg = raw[VALUE_W-1];
   assign raw_mag = raw_neg ? value_type'(32'd0 - raw) : raw;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign load_ok       = !rsp_valid_ff || rsp_bus.ready;

   assign div_start    = accept || ((state_ff == ST_DIV) && (quotient != '0));
   assign div_dividend = accept ? raw_mag : quotient;

   sidc_div10 u_div10 (
      .clock     (clock),
      .start     (div_start),
      .dividend  (div_dividend),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      ndig_in      = ndig_ff;
      idx_in       = idx_ff;
      sign_pend_in = sign_pend_ff;
      done_in      = done_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in   = raw_neg;
               ndig_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            ndig_in = ndig_ff + didx_type'(1);
            if (quotient == '0) begin
               idx_in       = ndig_ff;
               sign_pend_in = neg_ff;
               done_in      = 1'b0;
               count_in     = '0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (load_ok) begin
               if (done_ff) begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = count_ff + count_type'(1);
                  count_in     = count_ff + count_type'(1);
                  if (sign_pend_ff) begin
                     rsp_char_in  = CHAR_MINUS;
                     rsp_last_in  = 1'b0;
                     sign_pend_in = 1'b0;
                  end else begin
                     rsp_char_in = CHAR_ZERO + char_type'(digits_ff[idx_ff]);
                     rsp_last_in = (idx_ff == LAST_DIGIT_IDX);
                     if (idx_ff == LAST_DIGIT_IDX) begin
                        done_in = 1'b1;
                     end else begin
                        idx_in = idx_ff - didx_type'(1);
                     end
                  end
               end
            end
         end
         default: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         neg_ff       <= 1'b0;
         ndig_ff      <= '0;
         idx_ff       <= '0;
         sign_pend_ff <= 1'b0;
         done_ff      <= 1'b0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         neg_ff       <= neg_in;
         ndig_ff      <= ndig_in;
         idx_ff       <= idx_in;
         sign_pend_ff <= sign_pend_in;
         done_ff      <= done_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff  <= rsp_char_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
      // digits land least significant first
      if (state_ff == ST_DIV) begin
         digits_ff[ndig_ff] <= remainder;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.character    = rsp_char_ff;
   assign rsp_bus.chars_so_far = rsp_count_ff;
   assign rsp_bus.last         = rsp_last_ff;

endmodule
